// ===== src/assert_macros.svh =====
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dpalu_pkg.sv =====
// Opcodes, flag positions and widths of the data-processing ALU.
package dpalu_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FLAGS_W = 4;

  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } op_t;

endpackage

// ===== src/arm_data_processing_alu_unit.sv =====
// Data-processing ALU with NZCV generation: input register, ALU, result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | operation, set_flags, dest_is_pc,
//           |           |                     | mode_has_spsr, first_operand,
//           |           |                     | shifter_value, shifter_carry, flags_in
//   out_    | output    | out_valid/out_stall | result, write_result, flags_out,
//           |           |                     | restore_status, unpredictable
//
// out_valid comes via input and result registers; one per cycle unless out_stall.
// The single 33-bit adder between the input and result registers sets the clock.
// Reset is synchronous on rst_n and empties both stages.
// in_stall rises only when both stages hold items and out_stall is high, so the
// input register keeps filling while a finished result waits.
`include "assert_macros.svh"

module arm_data_processing_alu_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          in_operation,
  input  logic                                in_set_flags,
  input  logic                                in_dest_is_pc,
  input  logic                                in_mode_has_spsr,
  input  logic [dpalu_pkg::DATA_W-1:0]        in_first_operand,
  input  logic [dpalu_pkg::DATA_W-1:0]        in_shifter_value,
  input  logic                                in_shifter_carry,
  input  logic [dpalu_pkg::FLAGS_W-1:0]       in_flags_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dpalu_pkg::DATA_W-1:0]        out_result,
  output logic                                out_write_result,
  output logic [dpalu_pkg::FLAGS_W-1:0]       out_flags_out,
  output logic                                out_restore_status,
  output logic                                out_unpredictable
);

  localparam int unsigned W = dpalu_pkg::DATA_W;

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  dpalu_pkg::op_t                    s1_op_r;
  logic                              s1_set_flags_r;
  logic                              s1_dest_is_pc_r;
  logic                              s1_mode_has_spsr_r;
  logic [W-1:0]                      s1_a_r;
  logic [W-1:0]                      s1_b_r;
  logic                              s1_shifter_carry_r;
  logic [dpalu_pkg::FLAGS_W-1:0]     s1_flags_r;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [W-1:0]                      out_result_r;
  logic                              out_write_result_r;
  logic [dpalu_pkg::FLAGS_W-1:0]     out_flags_out_r;
  logic                              out_restore_status_r;
  logic                              out_unpredictable_r;

  logic                              in_take;
  logic                              s2_load;

  logic [W-1:0]                      add_x;
  logic [W-1:0]                      add_y;
  logic                              add_cin;
  logic [W:0]                        add_sum;
  logic                              arith;
  logic                              compare;
  logic [W-1:0]                      res_nxt;
  logic                              n_flag;
  logic                              z_flag;
  logic                              c_flag;
  logic                              v_flag;
  logic [dpalu_pkg::FLAGS_W-1:0]     flags_new;
  logic [dpalu_pkg::FLAGS_W-1:0]     flags_nxt;
  logic                              write_nxt;
  logic                              restore_nxt;
  logic                              unpred_nxt;

  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign s2_load  = s1_valid_r && !(out_valid_r && out_stall);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // adder operand selection
  always_comb begin
    add_x   = s1_a_r;
    add_y   = s1_b_r;
    add_cin = 1'b0;
    arith   = 1'b0;
    unique case (s1_op_r) inside
      dpalu_pkg::OP_SUB, dpalu_pkg::OP_CMP: begin
        add_y   = ~s1_b_r;
        add_cin = 1'b1;
        arith   = 1'b1;
      end
      dpalu_pkg::OP_RSB: begin
        add_x   = s1_b_r;
        add_y   = ~s1_a_r;
        add_cin = 1'b1;
        arith   = 1'b1;
      end
      dpalu_pkg::OP_ADD, dpalu_pkg::OP_CMN: begin
        arith   = 1'b1;
      end
      dpalu_pkg::OP_ADC: begin
        add_cin = s1_flags_r[dpalu_pkg::FLAG_C];
        arith   = 1'b1;
      end
      dpalu_pkg::OP_SBC: begin
        add_y   = ~s1_b_r;
        add_cin = s1_flags_r[dpalu_pkg::FLAG_C];
        arith   = 1'b1;
      end
      dpalu_pkg::OP_RSC: begin
        add_x   = s1_b_r;
        add_y   = ~s1_a_r;
        add_cin = s1_flags_r[dpalu_pkg::FLAG_C];
        arith   = 1'b1;
      end
      default: begin
        arith   = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};

  always_comb begin
    res_nxt = add_sum[W-1:0];
    unique case (s1_op_r) inside
      dpalu_pkg::OP_AND, dpalu_pkg::OP_TST: res_nxt = s1_a_r & s1_b_r;
      dpalu_pkg::OP_EOR, dpalu_pkg::OP_TEQ: res_nxt = s1_a_r ^ s1_b_r;
      dpalu_pkg::OP_ORR:                    res_nxt = s1_a_r | s1_b_r;
      dpalu_pkg::OP_MOV:                    res_nxt = s1_b_r;
      dpalu_pkg::OP_BIC:                    res_nxt = s1_a_r & ~s1_b_r;
      dpalu_pkg::OP_MVN:                    res_nxt = ~s1_b_r;
      default:                              res_nxt = add_sum[W-1:0];
    endcase
  end

  always_comb begin
    compare = 1'b0;
    unique case (s1_op_r) inside
      dpalu_pkg::OP_TST, dpalu_pkg::OP_TEQ,
      dpalu_pkg::OP_CMP, dpalu_pkg::OP_CMN: compare = 1'b1;
      default:                              compare = 1'b0;
    endcase
  end

  assign n_flag    = res_nxt[W-1];
  assign z_flag    = (res_nxt == '0);
  assign c_flag    = arith ? add_sum[W] : s1_shifter_carry_r;
  assign v_flag    = arith ? (~(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ res_nxt[W-1]))
                           : s1_flags_r[dpalu_pkg::FLAG_V];
  assign flags_new = {n_flag, z_flag, c_flag, v_flag};

  always_comb begin
    flags_nxt   = s1_flags_r;
    restore_nxt = 1'b0;
    unpred_nxt  = 1'b0;
    write_nxt   = !compare;
    if (compare) begin
      flags_nxt = flags_new;
    end else if (s1_set_flags_r) begin
      if (s1_dest_is_pc_r) begin
        restore_nxt = s1_mode_has_spsr_r;
        unpred_nxt  = !s1_mode_has_spsr_r;
      end else begin
        flags_nxt = flags_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r            <= dpalu_pkg::op_t'(in_operation);
      s1_set_flags_r     <= in_set_flags;
      s1_dest_is_pc_r    <= in_dest_is_pc;
      s1_mode_has_spsr_r <= in_mode_has_spsr;
      s1_a_r             <= in_first_operand;
      s1_b_r             <= in_shifter_value;
      s1_shifter_carry_r <= in_shifter_carry;
      s1_flags_r         <= in_flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_result_r         <= res_nxt;
      out_write_result_r   <= write_nxt;
      out_flags_out_r      <= flags_nxt;
      out_restore_status_r <= restore_nxt;
      out_unpredictable_r  <= unpred_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_write_result   = out_write_result_r;
  assign out_flags_out      = out_flags_out_r;
  assign out_restore_status = out_restore_status_r;
  assign out_unpredictable  = out_unpredictable_r;

  `ASSERT_ALWAYS(a_stall_only_when_full, clk, in_stall |-> (s1_valid_r && out_valid_r),
    "input stalled with a free stage")
  `ASSERT_CLK(a_advance_fills_output, clk, rst_n,
    (s1_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r, "stage 1 item not advanced")
  `ASSERT_CLK(a_indications_exclusive, clk, rst_n,
    out_valid_r |-> !(out_restore_status_r && out_unpredictable_r), "restore and unpredictable")
  `ASSERT_CLK(a_compare_no_indication, clk, rst_n,
    (out_valid_r && !out_write_result_r) |-> !(out_restore_status_r || out_unpredictable_r),
    "compare op raised an indication")
  `ASSERT_CLK(a_flags_kept_without_s, clk, rst_n,
    (s2_load && !compare && !s1_set_flags_r) |=> (out_flags_out_r == $past(s1_flags_r)),
    "flags changed with S clear")

endmodule
